// ----- sv/scancode_set1_decoder_fifo_defines.svh -----
// Assertion helpers for the scancode set 1 decoder.
`ifndef SCANCODE_SET1_DECODER_FIFO_DEFINES_SVH
`define SCANCODE_SET1_DECODER_FIFO_DEFINES_SVH

// Checked only while out of reset.
`define SCS1_ASSERT(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) expr) \
    else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define SCS1_ASSERT_ALWAYS(name, clk, expr) \
  name: assert property (@(posedge clk) expr) else $error("%m: assertion failed");

`endif

// ----- sv/scs1_pkg.sv -----
`default_nettype none

package scs1_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int TABLE_LEN  = 58;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  localparam logic [7:0] SC_PREFIX = 8'hE0;
  localparam logic [7:0] SC_BREAK  = 8'h80;
  localparam logic [6:0] SC_MAKE   = 7'h7F;
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_LCTRL  = 7'h1D;
  localparam logic [7:0] SC_C      = 8'h2E;
  localparam logic [7:0] SC_UP     = 8'h48;
  localparam logic [7:0] SC_DOWN   = 8'h50;
  localparam logic [7:0] SC_LEFT   = 8'h4B;
  localparam logic [7:0] SC_RIGHT  = 8'h4D;
  localparam logic [7:0] SC_DEL    = 8'h53;
  localparam logic [7:0] SC_HOME   = 8'h47;
  localparam logic [7:0] SC_END    = 8'h4F;

  // Navigation key indices as queued with the special flag.
  localparam logic [7:0] NAV_UP    = 8'd0;
  localparam logic [7:0] NAV_DOWN  = 8'd1;
  localparam logic [7:0] NAV_LEFT  = 8'd2;
  localparam logic [7:0] NAV_RIGHT = 8'd3;
  localparam logic [7:0] NAV_DEL   = 8'd4;
  localparam logic [7:0] NAV_HOME  = 8'd5;
  localparam logic [7:0] NAV_END   = 8'd6;

  typedef struct packed {
    logic       special;
    logic [7:0] code;
  } key_entry_t;

  typedef struct packed {
    logic       push;
    key_entry_t entry;
  } key_req_t;

  localparam logic [7:0] PLAIN_MAP [0:TABLE_LEN-1] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  localparam logic [7:0] UPPER_MAP [0:TABLE_LEN-1] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

endpackage

`default_nettype wire

// ----- sv/scancode_set1_decoder_fifo.sv -----
// Scancode set 1 keyboard decoder with a queue of decoded keys. Each input
// request is either a received scancode byte (in_tuser = 0, byte in
// in_tdata) or a read of one decoded key (in_tuser = 1). Shift, left ctrl
// and the 0xE0 prefix are tracked; printable make codes become ASCII,
// extended arrow/delete/home/end keys are queued as indices 0..6 with the
// special flag (out_tuser). Ctrl+C is flagged on its scancode's result and
// not queued. The queue holds FIFO_DEPTH-1 keys and drops new keys when
// full. Every input request gives exactly one result request. Rate: one
// request per clock while the output is not stalled. A request passes the
// input register, then the result register, which for reads is the key
// RAM's registered read port. The input side stays ready while a result
// waits, as long as the input register is free.
`default_nettype none

module scancode_set1_decoder_fifo (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] scancode
  input  wire logic        in_tuser,   // [0] command: 0 scancode, 1 read
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // [0] read_valid, [8:1] read_code,
                                       // [9] ctrl_c_event, [15:10] zero
  output      logic        out_tuser   // [0] read_special
);

  import scs1_pkg::*;

  // Input register (stage A)
  logic       a_valid_r, a_valid_nxt;
  cmd_t       a_cmd_r;
  logic [7:0] a_sc_r;

  // Result register (stage B); key data sits in the RAM read register
  logic       b_valid_r, b_valid_nxt;
  logic       b_hit_r;
  logic       b_ctrl_c_r;

  logic       b_load;
  logic       a_fire;
  logic       in_fire;
  key_req_t   key_req;
  logic       ctrl_c;
  logic       pop_hit;
  key_entry_t rd_entry;

  assign b_load    = !b_valid_r || out_tready;
  assign a_fire    = a_valid_r && b_load;
  assign in_tready = !a_valid_r || b_load;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (a_fire) begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = b_valid_r;
    if (b_load) begin
      b_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_cmd_r <= cmd_t'(in_tuser);
      a_sc_r  <= in_tdata;
    end
    if (a_fire) begin
      b_hit_r    <= pop_hit;
      b_ctrl_c_r <= ctrl_c;
    end
  end

  scs1_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (a_fire && (a_cmd_r == CMD_SCAN)),
    .scancode (a_sc_r),
    .key_req  (key_req),
    .ctrl_c   (ctrl_c)
  );

  scs1_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_req  (key_req),
    .pop      (a_fire && (a_cmd_r == CMD_READ)),
    .pop_hit  (pop_hit),
    .rd_entry (rd_entry)
  );

  // RAM read data only counts on a hit; otherwise code and flag read zero.
  assign out_tvalid = b_valid_r;
  assign out_tdata  = {6'b0, b_ctrl_c_r, (b_hit_r ? rd_entry.code : 8'h00), b_hit_r};
  assign out_tuser  = b_hit_r && rd_entry.special;

endmodule

`default_nettype wire

// ----- sv/scs1_ram.sv -----
`default_nettype none

module scs1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/scs1_decode.sv -----
`default_nettype none

module scs1_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,      // scancode request leaves the input register
  input  wire logic [7:0]        scancode,
  output      scs1_pkg::key_req_t key_req,
  output      logic              ctrl_c
);

  import scs1_pkg::*;

  logic shift_r, shift_nxt;
  logic ctrl_r, ctrl_nxt;
  logic prefix_r, prefix_nxt;
  logic [7:0] ch;

  always_comb begin
    ch = '0;
    if (scancode < 8'(TABLE_LEN)) begin
      ch = shift_r ? UPPER_MAP[scancode[5:0]] : PLAIN_MAP[scancode[5:0]];
    end
  end

  always_comb begin
    shift_nxt  = shift_r;
    ctrl_nxt   = ctrl_r;
    prefix_nxt = prefix_r;
    key_req    = '0;
    ctrl_c     = 1'b0;
    if (fire) begin
      if (scancode == SC_PREFIX) begin
        prefix_nxt = 1'b1;
      end else if (prefix_r) begin
        prefix_nxt = 1'b0;
        key_req.entry.special = 1'b1;
        case (scancode)
          SC_UP:    key_req.entry.code = NAV_UP;
          SC_DOWN:  key_req.entry.code = NAV_DOWN;
          SC_LEFT:  key_req.entry.code = NAV_LEFT;
          SC_RIGHT: key_req.entry.code = NAV_RIGHT;
          SC_DEL:   key_req.entry.code = NAV_DEL;
          SC_HOME:  key_req.entry.code = NAV_HOME;
          SC_END:   key_req.entry.code = NAV_END;
          default:  key_req.entry.special = 1'b0;
        endcase
        key_req.push = key_req.entry.special;
      end else if ((scancode & SC_BREAK) != '0) begin
        if ((scancode[6:0] & SC_MAKE) inside {SC_LSHIFT, SC_RSHIFT}) begin
          shift_nxt = 1'b0;
        end
        if ((scancode[6:0] & SC_MAKE) == SC_LCTRL) begin
          ctrl_nxt = 1'b0;
        end
      end else if (scancode[6:0] inside {SC_LSHIFT, SC_RSHIFT}) begin
        shift_nxt = 1'b1;
      end else if (scancode[6:0] == SC_LCTRL) begin
        ctrl_nxt = 1'b1;
      end else if (ctrl_r && scancode == SC_C) begin
        ctrl_c = 1'b1;
      end else begin
        key_req.entry.code = ch;
        key_req.push       = (ch != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= 1'b0;
      ctrl_r   <= 1'b0;
      prefix_r <= 1'b0;
    end else begin
      shift_r  <= shift_nxt;
      ctrl_r   <= ctrl_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/scs1_fifo.sv -----
`default_nettype none

module scs1_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire scs1_pkg::key_req_t  key_req,
  input  wire logic                pop,       // read request leaves the input register
  output      logic                pop_hit,   // queue was not empty for that read
  output      scs1_pkg::key_entry_t rd_entry  // valid the cycle after a hit
);

  import scs1_pkg::*;

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_next, rd_next;
  logic             do_write;

  assign wr_next = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_next = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  // Full keeps one slot open; a key arriving then is dropped.
  assign do_write = key_req.push && (wr_next != rd_ptr_r);
  assign pop_hit  = pop && (rd_ptr_r != wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = do_write ? wr_next : wr_ptr_r;
    rd_ptr_nxt = pop_hit  ? rd_next : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  scs1_ram #(
    .WIDTH ($bits(key_entry_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_ptr_r),
    .wdata (key_req.entry),
    .re    (pop_hit),
    .raddr (rd_ptr_r),
    .rdata (rd_entry)
  );

endmodule

`default_nettype wire

// ----- sv/scs1_checker.sv -----
`default_nettype none
`include "scancode_set1_decoder_fifo_defines.svh"

module scs1_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);

  `SCS1_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `SCS1_ASSERT(a_ctrl_c_no_key, clk, rst_n, out_tvalid && out_tdata[9] |-> !out_tdata[0])
  `SCS1_ASSERT(a_empty_zero, clk, rst_n,
    out_tvalid && !out_tdata[0] |-> (out_tdata[8:1] == 8'h00) && !out_tuser)
  `SCS1_ASSERT(a_special_range, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[8:1] <= 8'd6)
  `SCS1_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> !out_tvalid)

endmodule

bind scancode_set1_decoder_fifo scs1_checker u_scs1_checker (.*);

`default_nettype wire
